### rtl/core/binary_signature_scanner_assert.svh
// Assertion macros used by the scanner checker.
// Each macro takes a label, a trigger condition, a consequence and a message.
`ifndef BINARY_SIGNATURE_SCANNER_ASSERT_SVH
`define BINARY_SIGNATURE_SCANNER_ASSERT_SVH

// Consequence holds in the same cycle as the trigger.
`define BSS_ASSERT_NOW(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// Consequence holds in the cycle after the trigger.
`define BSS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bss_pkg.sv
package bss_pkg;

  localparam int WINDOW_BYTES = 21;
  localparam int MARKER_COUNT = 20;
  localparam int COUNT_W      = 32;
  localparam int TextW        = WINDOW_BYTES * 8;
  localparam int MagicLen     = 4;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(134217728);

  // Marker strings, right aligned: the last character sits in the low byte.
  localparam logic [TextW-1:0] MARK_TEXT [MARKER_COUNT] = '{
    TextW'({"Chr", "ome_RendererMain"}),
    TextW'("ContentMainRunner"),
    TextW'("content::ContentMain"),
    TextW'("blink::Web"),
    TextW'("cef_execute_process"),
    TextW'({"QtWebEng", "ineCore"}),
    TextW'("XRE_Main"),
    TextW'("XREMain"),
    TextW'("NS_InitXPCOM2"),
    TextW'("nsStandardURL"),
    TextW'("GeckoChildProcessHost"),
    TextW'("XRE_GetBootstrap"),
    TextW'("SetGeckoProcessType"),
    TextW'("mozilla::dom::"),
    TextW'("WebKitWebProcessMain"),
    TextW'("WebKitNetworkProcess"),
    TextW'("WebProcessPool"),
    TextW'("WebCore::"),
    TextW'("WTF::URL"),
    TextW'("webkit_web_view")
  };

  // Markers of each engine family.
  localparam logic [MARKER_COUNT-1:0] FAM_BLINK_MASK  = MARKER_COUNT'(20'h0003F);
  localparam logic [MARKER_COUNT-1:0] FAM_GECKO_MASK  = MARKER_COUNT'(20'h03FC0);
  localparam logic [MARKER_COUNT-1:0] FAM_WEBKIT_MASK = MARKER_COUNT'(20'hFC000);

  localparam logic [7:0] ELF_MAGIC [MagicLen] = '{8'h7f, 8'h45, 8'h4c, 8'h46};

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CANDIDATE = 2'd1,
    ST_PROBABLE  = 2'd2
  } status_t;

  // One window byte moving down the chain.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } link_t;

  // Expected byte of one marker at one window position.
  typedef struct packed {
    logic       care;
    logic [7:0] ch;
  } pat_t;

  typedef pat_t [MARKER_COUNT-1:0] col_t;

  // Per-beat controls fanned out to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic                    is_elf;
    logic                    complete;
    status_t                 blink_status;
    status_t                 gecko_status;
    status_t                 webkit_status;
    logic [MARKER_COUNT-1:0] matched_markers;
    logic [COUNT_W-1:0]      bytes_scanned;
  } result_t;

  // Column of expected bytes for window position pos (0 oldest).
  function automatic col_t pattern_col(input int pos);
    col_t col;
    int   from_end;
    from_end = WINDOW_BYTES - 1 - pos;
    for (int m = 0; m < MARKER_COUNT; m++) begin
      col[m].ch   = MARK_TEXT[m][from_end*8 +: 8];
      col[m].care = (col[m].ch != 8'h00);
    end
    return col;
  endfunction

  // Grade a family by how many of its markers were found.
  function automatic status_t status_of(input logic [MARKER_COUNT-1:0] v);
    logic any_hit;
    logic multi_hit;
    any_hit   = |v;
    multi_hit = |(v & (v - MARKER_COUNT'(1)));
    if (multi_hit) begin
      return ST_PROBABLE;
    end else if (any_hit) begin
      return ST_CANDIDATE;
    end else begin
      return ST_NONE;
    end
  endfunction

endpackage

### rtl/core/binary_signature_scanner.sv
// Binary signature scanner: takes one file byte per beat and, on the beat
// flagged last_byte, queues one result with the ELF check, the 20-bit found
// marker map, three family grades and the examined byte count. A byte enters
// every cycle while in_ready is high: it shifts into a 21-cell window chain and
// all markers are compared against the shifted window in that same cycle,
// so the result of a file is formed on its last byte and registered into the
// two-entry result queue, which lets bytes keep flowing while a result waits;
// in_ready falls only when two results are waiting. Bytes beyond byte_limit
// are not examined and clear the complete flag. byte_limit may be rewritten
// only between files.
module binary_signature_scanner (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [bss_pkg::COUNT_W-1:0]           cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            data_byte,
  input  logic                                  last_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  is_elf,
  output logic                                  complete,
  output logic [1:0]                            blink_status,
  output logic [1:0]                            gecko_status,
  output logic [1:0]                            webkit_status,
  output logic [bss_pkg::MARKER_COUNT-1:0]      matched_markers,
  output logic [bss_pkg::COUNT_W-1:0]           bytes_scanned
);

  logic [bss_pkg::COUNT_W-1:0]      byte_limit;
  logic [bss_pkg::COUNT_W-1:0]      byte_count;
  logic [bss_pkg::COUNT_W-1:0]      byte_count_next;
  logic [bss_pkg::MARKER_COUNT-1:0] found;
  logic [bss_pkg::MARKER_COUNT-1:0] found_next;
  logic                             magic_ok;
  logic                             magic_ok_next;
  logic                             dropped;
  logic                             dropped_next;

  logic                             accept;
  logic                             take;
  logic                             buf_full;
  bss_pkg::cell_ctl_t               ctl;
  bss_pkg::link_t                   new_link;
  bss_pkg::link_t                   link [bss_pkg::WINDOW_BYTES];
  logic [bss_pkg::MARKER_COUNT-1:0] hit_cell [bss_pkg::WINDOW_BYTES];
  logic [bss_pkg::MARKER_COUNT-1:0] hit_all;
  logic                             elf;
  logic [bss_pkg::MARKER_COUNT-1:0] flags;
  bss_pkg::result_t                 result;
  bss_pkg::result_t                 head;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;
  assign take     = accept && (byte_count < byte_limit);

  assign ctl.shift = take;
  assign ctl.clear = accept && last_byte;
  assign new_link  = '{valid: 1'b1, data: data_byte};

  // Window chain: newest byte enters at the top cell and moves down
  for (genvar p = 0; p < bss_pkg::WINDOW_BYTES; p++) begin : g_cell
    if (p == bss_pkg::WINDOW_BYTES - 1) begin : g_top
      bss_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .link_in  (new_link),
        .pattern  (bss_pkg::pattern_col(p)),
        .link_out (link[p]),
        .hit      (hit_cell[p])
      );
    end else begin : g_mid
      bss_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .link_in  (link[p+1]),
        .pattern  (bss_pkg::pattern_col(p)),
        .link_out (link[p]),
        .hit      (hit_cell[p])
      );
    end
  end

  // Combine per-cell hits into whole-marker matches
  always_comb begin
    hit_all = '1;
    for (int p = 0; p < bss_pkg::WINDOW_BYTES; p++) begin
      hit_all = hit_all & hit_cell[p];
    end
  end

  // Per-file state after this beat
  always_comb begin
    byte_count_next = byte_count;
    found_next      = found;
    magic_ok_next   = magic_ok;
    dropped_next    = dropped;
    if (take) begin
      byte_count_next = byte_count + bss_pkg::COUNT_W'(1);
      found_next      = found | hit_all;
      if ((byte_count < bss_pkg::COUNT_W'(bss_pkg::MagicLen)) &&
          (data_byte != bss_pkg::ELF_MAGIC[byte_count[1:0]])) begin
        magic_ok_next = 1'b0;
      end
    end else if (accept) begin
      dropped_next = 1'b1;
    end
  end

  // Hold per-file state; clear it after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      found      <= '0;
      magic_ok   <= 1'b1;
      dropped    <= 1'b0;
    end else if (accept && last_byte) begin
      byte_count <= '0;
      found      <= '0;
      magic_ok   <= 1'b1;
      dropped    <= 1'b0;
    end else if (accept) begin
      byte_count <= byte_count_next;
      found      <= found_next;
      magic_ok   <= magic_ok_next;
      dropped    <= dropped_next;
    end
  end

  // Byte limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= bss_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      byte_limit <= cfg_wr_data;
    end
  end

  // Build the file result
  assign elf   = magic_ok_next && (byte_count_next >= bss_pkg::COUNT_W'(bss_pkg::MagicLen));
  assign flags = elf ? found_next : '0;

  always_comb begin
    result.is_elf          = elf;
    result.complete        = !dropped_next;
    result.blink_status    = bss_pkg::status_of(flags & bss_pkg::FAM_BLINK_MASK);
    result.gecko_status    = bss_pkg::status_of(flags & bss_pkg::FAM_GECKO_MASK);
    result.webkit_status   = bss_pkg::status_of(flags & bss_pkg::FAM_WEBKIT_MASK);
    result.matched_markers = flags;
    result.bytes_scanned   = byte_count_next;
  end

  bss_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign is_elf          = head.is_elf;
  assign complete        = head.complete;
  assign blink_status    = head.blink_status;
  assign gecko_status    = head.gecko_status;
  assign webkit_status   = head.webkit_status;
  assign matched_markers = head.matched_markers;
  assign bytes_scanned   = head.bytes_scanned;

endmodule

### rtl/core/bss_cell.sv
module bss_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  bss_pkg::cell_ctl_t                  ctl,
  input  bss_pkg::link_t                      link_in,
  input  bss_pkg::col_t                       pattern,
  output bss_pkg::link_t                      link_out,
  output logic [bss_pkg::MARKER_COUNT-1:0]    hit
);

  bss_pkg::link_t held;
  bss_pkg::link_t cur;

  // Window byte as it stands after this beat's shift
  assign cur = ctl.shift ? link_in : held;

  // Compare against every marker's byte at this position
  always_comb begin
    for (int m = 0; m < bss_pkg::MARKER_COUNT; m++) begin
      hit[m] = !pattern[m].care || (cur.valid && (cur.data == pattern[m].ch));
    end
  end

  // Valid bit: drop at end of file, advance on shift; byte: advance on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (ctl.clear) begin
      held.valid <= 1'b0;
    end else if (ctl.shift) begin
      held.valid <= link_in.valid;
    end
    if (ctl.shift) begin
      held.data <= link_in.data;
    end
  end

  assign link_out = held;

endmodule

### rtl/core/bss_result_buf.sv
module bss_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bss_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output bss_pkg::result_t head
);

  bss_pkg::result_t tail;
  logic             head_valid;
  logic             tail_valid;
  logic             pop;

  assign pop = head_valid && out_ready;

  // Two-entry queue: head drives the port, tail catches a beat while head waits
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop) begin
      if (tail_valid) begin
        head       <= tail;
        tail_valid <= push;
        if (push) begin
          tail <= push_data;
        end
      end else begin
        head_valid <= push;
        if (push) begin
          head <= push_data;
        end
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
        head       <= push_data;
      end else begin
        tail_valid <= 1'b1;
        tail       <= push_data;
      end
    end
  end

  assign full      = tail_valid;
  assign out_valid = head_valid;

endmodule

### rtl/core/bss_checker.sv
`include "binary_signature_scanner_assert.svh"

module bss_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  is_elf,
  input logic [1:0]                            blink_status,
  input logic [1:0]                            gecko_status,
  input logic [1:0]                            webkit_status,
  input logic [bss_pkg::MARKER_COUNT-1:0]      matched_markers,
  input logic [bss_pkg::COUNT_W-1:0]           bytes_scanned
);

  // A stalled result keeps its byte count
  `BSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bytes_scanned), "result changed while stalled")

  // Without the ELF magic no marker is reported
  `BSS_ASSERT_NOW(a_no_elf_quiet, out_valid && !is_elf, (matched_markers == '0) && (blink_status == bss_pkg::ST_NONE) && (gecko_status == bss_pkg::ST_NONE) && (webkit_status == bss_pkg::ST_NONE), "markers reported for non-ELF file")

  // An ELF verdict needs the four magic bytes examined
  `BSS_ASSERT_NOW(a_elf_len, out_valid && is_elf, bytes_scanned >= bss_pkg::COUNT_W'(bss_pkg::MagicLen), "ELF reported on short file")

  // Gecko grade agrees with the marker map
  `BSS_ASSERT_NOW(a_gecko_grade, out_valid, (gecko_status == bss_pkg::ST_NONE) == ((matched_markers & bss_pkg::FAM_GECKO_MASK) == '0), "gecko grade disagrees with map")

endmodule

bind binary_signature_scanner bss_checker u_bss_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .is_elf          (is_elf),
  .blink_status    (blink_status),
  .gecko_status    (gecko_status),
  .webkit_status   (webkit_status),
  .matched_markers (matched_markers),
  .bytes_scanned   (bytes_scanned)
);

### dv/binary_signature_scanner_tb.sv
`timescale 1ns / 100ps

module binary_signature_scanner_tb;

  localparam int WIN          = bss_pkg::WINDOW_BYTES;
  localparam int SIGW         = WIN * 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SIG_XREMAIN  = 7;
  localparam int SIG_WTF_URL  = 18;

  // Marker strings, right aligned: the last character sits in the low byte.
  localparam logic [SIGW-1:0] SIG_TEXT [bss_pkg::MARKER_COUNT] = '{
    SIGW'({"Chr", "ome_RendererMain"}),
    SIGW'("ContentMainRunner"),
    SIGW'("content::ContentMain"),
    SIGW'("blink::Web"),
    SIGW'("cef_execute_process"),
    SIGW'({"QtWebEng", "ineCore"}),
    SIGW'("XRE_Main"),
    SIGW'("XREMain"),
    SIGW'("NS_InitXPCOM2"),
    SIGW'("nsStandardURL"),
    SIGW'("GeckoChildProcessHost"),
    SIGW'("XRE_GetBootstrap"),
    SIGW'("SetGeckoProcessType"),
    SIGW'("mozilla::dom::"),
    SIGW'("WebKitWebProcessMain"),
    SIGW'("WebKitNetworkProcess"),
    SIGW'("WebProcessPool"),
    SIGW'("WebCore::"),
    SIGW'("WTF::URL"),
    SIGW'("webkit_web_view")
  };

  localparam int FAM_FIRST [3] = '{0, 6, 14};
  localparam int FAM_LAST  [3] = '{5, 13, 19};

  localparam logic [7:0] MAGIC [4] = '{8'h7f, 8'h45, 8'h4c, 8'h46};

  typedef enum { HEAD_ELF, HEAD_BROKEN, HEAD_SHORT, HEAD_NONE } head_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [bss_pkg::COUNT_W-1:0]      cfg_wr_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       data_byte = 8'h00;
  logic                             last_byte = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             is_elf;
  logic                             complete;
  logic [1:0]                       blink_status;
  logic [1:0]                       gecko_status;
  logic [1:0]                       webkit_status;
  logic [bss_pkg::MARKER_COUNT-1:0] matched_markers;
  logic [bss_pkg::COUNT_W-1:0]      bytes_scanned;

  // Bytes waiting to be driven and file reports waiting to come out
  beat_t            file_beats [$];
  bss_pkg::result_t pending_reports [$];

  // Scanner state as predicted
  logic [bss_pkg::COUNT_W-1:0]      limit_now = bss_pkg::LIMIT_RESET;
  logic [7:0]                       win [WIN];
  logic [bss_pkg::MARKER_COUNT-1:0] seen;
  logic [bss_pkg::COUNT_W-1:0]      examined;
  logic                             head_ok;
  logic                             cut_short;

  int    beats_queued   = 0;
  int    beats_accepted = 0;
  int    mismatches     = 0;
  int    cycle_cnt      = 0;
  int    in_gap         = 0;
  int    in_calm        = 0;
  int    out_hold       = 0;
  int    out_calm       = 0;
  logic  in_fire        = 1'b0;
  beat_t nxt;
  bss_pkg::result_t got;
  bss_pkg::result_t want;

  binary_signature_scanner u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .is_elf          (is_elf),
    .complete        (complete),
    .blink_status    (blink_status),
    .gecko_status    (gecko_status),
    .webkit_status   (webkit_status),
    .matched_markers (matched_markers),
    .bytes_scanned   (bytes_scanned)
  );

  always #5 clk = ~clk;

  function automatic int sig_len(input logic [SIGW-1:0] txt);
    int n = 0;
    for (int d = 0; d < WIN; d++) begin
      if (txt[d*8 +: 8] != 8'h00) n = d + 1;
    end
    return n;
  endfunction

  function automatic bss_pkg::status_t grade_family(input int n);
    return (n >= 2) ? bss_pkg::ST_PROBABLE :
           ((n == 1) ? bss_pkg::ST_CANDIDATE : bss_pkg::ST_NONE);
  endfunction

  function automatic void clear_file();
    foreach (win[k]) win[k] = 8'h00;
    seen      = '0;
    examined  = '0;
    head_ok   = 1'b1;
    cut_short = 1'b0;
  endfunction

  // Most gaps short, a few long, and now and then a calm run with none
  function automatic int idle_len(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Fold one accepted byte into the scan; on the last byte queue the report
  task automatic scan_byte(input logic [7:0] b, input logic fin);
    bss_pkg::result_t rpt;
    int               hits [3];
    int               len;
    logic             hit;
    if (examined < limit_now) begin
      if (examined < 4 && b != MAGIC[examined[1:0]]) head_ok = 1'b0;
      for (int k = 0; k < WIN - 1; k++) win[k] = win[k+1];
      win[WIN-1] = b;
      examined = examined + 1;
      for (int m = 0; m < bss_pkg::MARKER_COUNT; m++) begin
        len = sig_len(SIG_TEXT[m]);
        hit = (examined >= len);
        for (int d = 0; d < len; d++) begin
          if (win[WIN-1-d] != SIG_TEXT[m][d*8 +: 8]) hit = 1'b0;
        end
        if (hit) seen[m] = 1'b1;
      end
    end else begin
      cut_short = 1'b1;
    end
    if (fin) begin
      rpt.is_elf          = head_ok && (examined >= 4);
      rpt.complete        = !cut_short;
      rpt.matched_markers = rpt.is_elf ? seen : '0;
      hits = '{0, 0, 0};
      for (int m = 0; m < bss_pkg::MARKER_COUNT; m++) begin
        if (rpt.matched_markers[m]) hits[(m < 6) ? 0 : ((m < 14) ? 1 : 2)]++;
      end
      rpt.blink_status  = grade_family(hits[0]);
      rpt.gecko_status  = grade_family(hits[1]);
      rpt.webkit_status = grade_family(hits[2]);
      rpt.bytes_scanned = examined;
      pending_reports = {pending_reports, rpt};
      clear_file();
    end
  endtask

  // Append a marker, leaving off its last drop characters
  task automatic add_marker(ref logic [7:0] body [$], input int m, input int drop);
    for (int d = sig_len(SIG_TEXT[m]) - 1; d >= drop; d--) begin
      body = {body, SIG_TEXT[m][d*8 +: 8]};
    end
  endtask

  task automatic queue_bytes(input logic [7:0] body [$]);
    beat_t bt;
    foreach (body[k]) begin
      bt.data    = body[k];
      bt.last    = (k == body.size() - 1);
      file_beats = {file_beats, bt};
    end
    beats_queued += body.size();
  endtask

  // Build one file: a header (full, broken, short or none), markers with random padding, a random tail
  task automatic queue_file(input head_kind_t kind, input int n_marks, input int pad_max);
    logic [7:0] body [$];
    int         fam;
    int         m;
    int         keep;
    case (kind)
      HEAD_ELF, HEAD_BROKEN: begin
        for (int k = 0; k < 4; k++) body = {body, MAGIC[k]};
      end
      HEAD_SHORT: begin
        keep = $urandom_range(1, 3);
        for (int k = 0; k < keep; k++) body = {body, MAGIC[k]};
      end
      default: begin
      end
    endcase
    if (kind == HEAD_BROKEN) body[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
    fam = $urandom_range(0, 2);
    for (int i = 0; i < n_marks; i++) begin
      repeat ($urandom_range(0, pad_max)) body = {body, 8'($urandom)};
      // favor one family per file so that probable grades show up
      if ($urandom_range(0, 9) < 7) m = $urandom_range(FAM_FIRST[fam], FAM_LAST[fam]);
      else m = $urandom_range(0, bss_pkg::MARKER_COUNT - 1);
      if ($urandom_range(0, 9) == 0) add_marker(body, m, $urandom_range(1, sig_len(SIG_TEXT[m]) - 1));
      else add_marker(body, m, 0);
    end
    repeat ($urandom_range(0, pad_max)) body = {body, 8'($urandom)};
    if (body.size() == 0) body = {body, 8'($urandom)};
    queue_bytes(body);
  endtask

  task automatic queue_random(input int n_files);
    int r;
    for (int f = 0; f < n_files; f++) begin
      r = $urandom_range(0, 99);
      if (r < 60) queue_file(HEAD_ELF, $urandom_range(1, 3), $urandom_range(0, 4));
      else if (r < 72) queue_file(HEAD_BROKEN, $urandom_range(1, 2), 3);
      else if (r < 80) queue_file(HEAD_ELF, 0, $urandom_range(0, 10));
      else if (r < 90) queue_file(HEAD_NONE, $urandom_range(0, 2), 6);
      else queue_file(HEAD_SHORT, 0, 0);
    end
  endtask

  // Wait until every byte is in and every report is out, then let the block drain
  task automatic settle();
    do @(negedge clk); while (beats_accepted != beats_queued || pending_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [bss_pkg::COUNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_now = v;
  endtask

  // Drive bytes: advance on each accepted beat, hold otherwise
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (file_beats.size() > 0) begin
        nxt = file_beats.pop_front();
        in_valid  <= 1'b1;
        data_byte <= nxt.data;
        last_byte <= nxt.last;
        in_gap = idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_hold = idle_len(out_calm);
    end
  end

  // Predict on accepted bytes, check accepted reports
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      beats_accepted++;
      scan_byte(data_byte, last_byte);
    end
    if (!rst && out_valid && out_ready) begin
      got = {is_elf, complete, blink_status, gecko_status, webkit_status,
             matched_markers, bytes_scanned};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report with none pending: markers %05h scanned %0d",
                   matched_markers, bytes_scanned);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch (exp/got): elf %0b/%0b complete %0b/%0b",
                     want.is_elf, got.is_elf, want.complete, got.complete);
            $display("  status %0d %0d %0d / %0d %0d %0d", want.blink_status,
                     want.gecko_status, want.webkit_status, got.blink_status,
                     got.gecko_status, got.webkit_status);
            $display("  markers %05h/%05h scanned %0d/%0d", want.matched_markers,
                     got.matched_markers, want.bytes_scanned, got.bytes_scanned);
          end
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL binary_signature_scanner");
      $finish;
    end
  end

  initial begin
    logic [7:0]                  body [$];
    logic [bss_pkg::COUNT_W-1:0] plan [6];
    clear_file();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte files at both extremes, a cut-off magic, a bare ELF header,
    // an ELF header with a marker, and a marker with no header
    body = '{8'h00};
    queue_bytes(body);
    body = '{8'hff};
    queue_bytes(body);
    body = '{8'h7f, 8'h45, 8'h4c};
    queue_bytes(body);
    body = {body, 8'h46};
    queue_bytes(body);
    add_marker(body, SIG_XREMAIN, 0);
    queue_bytes(body);
    body = {};
    add_marker(body, SIG_WTF_URL, 0);
    queue_bytes(body);
    queue_random(6);
    settle();

    // sweep the byte limit: zero, one, small, widest, moderate, back to reset value
    plan = '{32'd0, 32'd1, 32'($urandom_range(4, 30)), 32'hffff_ffff,
             32'($urandom_range(20, 80)), bss_pkg::LIMIT_RESET};
    foreach (plan[p]) begin
      write_limit(plan[p]);
      @(posedge clk);
      queue_random(4);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS binary_signature_scanner");
    end else begin
      $display("FAIL binary_signature_scanner");
    end
    $finish;
  end

endmodule
